// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked concurrent assertion, disabled while reset is asserted
`define SWTM_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// once cond is seen, sig keeps its value in the next cycle
`define SWTM_ASSERT_STAYS(lbl, clk, rstn, cond, sig, msg) \
	`SWTM_ASSERT_PROP(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

// File: hw/rtl/swtm_pkg.sv
// package: shared constants, types and codes of the trimmed mean block
package swtm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SAMPLE_W  = 16;
	localparam int AVERAGE_W = 16;
	localparam int WS_W      = 7;
	localparam int TRIM_W    = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [WS_W-1:0]   WS_RESET   = 7'd64;
	localparam logic [TRIM_W-1:0] TRIM_RESET = 5'd1;

	// register index, taken from the word address bit
	typedef enum logic {
		REG_WINDOW_SIZE = 1'b0,
		REG_TRIM_COUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REMOVE,
		ST_INSERT,
		ST_INSERT_LOW,
		ST_SUM,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// configuration handed from the register file to the datapath
	typedef struct packed {
		logic [WS_W-1:0]   window_size;
		logic [TRIM_W-1:0] trim_count;
		logic              restart;
	} cfg_t;

endpackage

// File: hw/rtl/swtm_if.sv
// stream interfaces: sample channel and result channel
interface swtm_smp_if;
	import swtm_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swtm_res_if;
	import swtm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [AVERAGE_W-1:0] average;
	logic                 valid_res;
	modport source (output valid, output average, output valid_res, input ready);
	modport sink (input valid, input average, input valid_res, output ready);
endinterface

// File: hw/rtl/sliding_window_trimmed_mean.sv
// top level: sliding window trimmed mean with sorted store and one divider
//
//   channel   kind          payload                     transfer when
//   smp       stream sink   sample[15:0]                smp.valid && smp.ready
//   res       stream source average[15:0], valid_res    res.valid && res.ready
//   apb       config slave  window_size @0, trim @4     psel && penable && pwrite
//
// one sample at a time; with n held samples, m the window and L = m - 2*trim,
// a sample runs at most an evict scan over the held entries, an insert scan,
// a sum of the L kept entries and a divide; the sorted ram port, one entry per
// cycle, and the one-bit-per-cycle divider set its duration.
// reset clears the control state; ram contents are undefined until written.
// the result register lets the next sample in while a result waits; a stalled
// result blocks only the finish of the following sample.
module sliding_window_trimmed_mean #(
	parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	swtm_smp_if.sink                     smp,
	swtm_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swtm_pkg::PADDR_W-1:0] paddr,
	input  logic [swtm_pkg::PDATA_W-1:0] pwdata,
	output logic [swtm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import swtm_pkg::*;

	localparam int AW    = $clog2(WINDOW_MAX);
	localparam int CW    = $clog2(WINDOW_MAX + 1);
	localparam int MW    = ((CW > 7) ? CW : 7) + 1;
	localparam int SB    = SAMPLE_BITS;
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

	cfg_t cfg;

	state_t state_q, state_d;

	// window arithmetic
	logic [MW-1:0] ws_x, m, k_x, len, wp_x, ev_x;
	logic          cfg_ok, evict, fin_ok;
	logic [AW-1:0] sum_first, sum_last, ev_slot;

	// sequencer registers
	logic [AW-1:0]    wp_q;
	logic [CW-1:0]    n_q;
	logic [SB-1:0]    v_q, e_q;
	logic [AW-1:0]    cnt_q, idx_s1;
	logic             pend_s1, found_q;
	logic [SUM_W-1:0] acc_q, acc_d;
	logic [AVERAGE_W-1:0] res_avg_q, avg_q;
	logic             res_ok_q, ok_q, out_valid_q;

	// ram ports
	logic          accept, rd_issue;
	logic [SB-1:0] r_rdata, s_rdata, s_wdata;
	logic          s_we;
	logic [AW-1:0] s_waddr;
	logic          data_gt, data_eq;

	// divider
	logic             div_start, div_done;
	logic [SUM_W-1:0] quotient;

	swtm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// window size capped at the store depth
	always_comb begin
		ws_x      = MW'(cfg.window_size);
		m         = (ws_x > MW'(WINDOW_MAX)) ? MW'(WINDOW_MAX) : ws_x;
		k_x       = MW'(cfg.trim_count);
		cfg_ok    = (m != '0) && ((k_x + k_x + MW'(1)) <= m);
		len       = m - k_x - k_x;
		sum_first = AW'(k_x);
		sum_last  = AW'(m - k_x - MW'(1));
		evict     = (MW'(n_q) == m);
		fin_ok    = cfg_ok && evict;
		// slot of the sample that leaves the window
		wp_x      = MW'(wp_q);
		ev_x      = (wp_x >= m) ? (wp_x - m) : (wp_x + MW'(WINDOW_MAX) - m);
		ev_slot   = AW'(ev_x);
	end

	assign accept  = smp.valid && smp.ready;
	assign data_gt = s_rdata > v_q;
	assign data_eq = s_rdata == e_q;
	assign acc_d   = acc_q + SUM_W'(s_rdata);

	// ring of raw samples: new sample written, oldest read in the same cycle
	swtm_ram #(.WIDTH(SB), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (SB'(smp.sample)),
		.raddr (ev_slot),
		.rdata (r_rdata)
	);

	// window contents in ascending order, entries 0 .. n-1
	swtm_ram #(.WIDTH(SB), .DEPTH(WINDOW_MAX)) u_sorted (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (cnt_q),
		.rdata (s_rdata)
	);

	swtm_div #(.NW(SUM_W), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_d),
		.divisor  (CW'(len)),
		.done     (div_done),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (smp.valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (m == '0) state_d = ST_FINISH;
				else if (evict) state_d = ST_REMOVE;
				else if (n_q == '0) state_d = ST_INSERT_LOW;
				else state_d = ST_INSERT;
			end
			ST_REMOVE: begin
				// last held entry seen: the evicted value is gone
				if (pend_s1 && idx_s1 == AW'(n_q - CW'(1))) begin
					state_d = (n_q == CW'(1)) ? ST_INSERT_LOW : ST_INSERT;
				end
			end
			ST_INSERT: begin
				if (pend_s1) begin
					if (!data_gt) state_d = fin_ok ? ST_SUM : ST_FINISH;
					else if (idx_s1 == '0) state_d = ST_INSERT_LOW;
				end
			end
			ST_INSERT_LOW: begin
				state_d = fin_ok ? ST_SUM : ST_FINISH;
			end
			ST_SUM: begin
				if (pend_s1 && idx_s1 == sum_last) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || res.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		smp.ready = (state_q == ST_IDLE);
		rd_issue  = state_q inside {ST_REMOVE, ST_INSERT, ST_SUM};
		div_start = (state_q == ST_SUM) && (state_d == ST_DIVIDE);
		s_we      = 1'b0;
		s_waddr   = idx_s1;
		s_wdata   = s_rdata;
		case (state_q)
			ST_REMOVE: begin
				// past the match every entry moves down one place
				s_we    = pend_s1 && found_q;
				s_waddr = idx_s1 - AW'(1);
			end
			ST_INSERT: begin
				// larger entries move up, the new sample lands above the first entry not larger
				s_we    = pend_s1;
				s_waddr = idx_s1 + AW'(1);
				s_wdata = data_gt ? s_rdata : v_q;
			end
			ST_INSERT_LOW: begin
				s_we    = 1'b1;
				s_waddr = '0;
				s_wdata = v_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// read data is used only while the same scan goes on
			pend_s1 <= rd_issue && (state_d == state_q);

			if (cfg.restart) begin
				wp_q <= '0;
				n_q  <= '0;
			end else begin
				if (accept) begin
					wp_q <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + AW'(1);
				end
				if (state_q == ST_LOAD && m != '0 && !evict) begin
					n_q <= n_q + CW'(1);
				end
			end

			if (state_q == ST_LOAD) begin
				found_q <= 1'b0;
			end else if (state_q == ST_REMOVE && pend_s1 && data_eq) begin
				found_q <= 1'b1;
			end

			// scan address
			if (state_d == ST_REMOVE && state_q != ST_REMOVE) begin
				cnt_q <= '0;
			end else if (state_d == ST_INSERT && state_q != ST_INSERT) begin
				cnt_q <= (state_q == ST_LOAD) ? AW'(n_q - CW'(1)) : AW'(n_q - CW'(2));
			end else if (state_d == ST_SUM && state_q != ST_SUM) begin
				cnt_q <= sum_first;
			end else begin
				case (state_q)
					ST_REMOVE, ST_SUM: cnt_q <= cnt_q + AW'(1);
					ST_INSERT:         cnt_q <= cnt_q - AW'(1);
					default: ;
				endcase
			end

			if (state_q == ST_FINISH && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			v_q <= SB'(smp.sample);
		end
		if (state_q == ST_LOAD) begin
			e_q <= r_rdata;
		end
		if (state_d == ST_SUM && state_q != ST_SUM) begin
			acc_q <= '0;
		end else if (state_q == ST_SUM && pend_s1) begin
			acc_q <= acc_d;
		end
		if (state_q == ST_DIVIDE && div_done) begin
			res_avg_q <= AVERAGE_W'(quotient);
			res_ok_q  <= 1'b1;
		end else if (state_d == ST_FINISH && state_q != ST_FINISH) begin
			// window not full, window size zero or trim too large
			res_avg_q <= '0;
			res_ok_q  <= 1'b0;
		end
		if (state_q == ST_FINISH && state_d == ST_IDLE) begin
			avg_q <= res_avg_q;
			ok_q  <= res_ok_q;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.average   = avg_q;
	assign res.valid_res = ok_q;

endmodule

// File: hw/rtl/swtm_ram.sv
// generic single write port, single read port ram with registered read
module swtm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/swtm_div.sv
// restoring divider, one quotient bit per cycle
module swtm_div #(
	parameter int NW = 22,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             qbit;

	always_comb begin
		rem_sh  = {rem_q, quo_q[NW-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		qbit    = rem_sh >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], qbit};
			rem_q <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/swtm_cfg.sv
// apb register file: window_size and trim_count
module swtm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swtm_pkg::PADDR_W-1:0] paddr,
	input  logic [swtm_pkg::PDATA_W-1:0] pwdata,
	output logic [swtm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output swtm_pkg::cfg_t               cfg
);
	import swtm_pkg::*;

	logic [WS_W-1:0]   ws_q;
	logic [TRIM_W-1:0] trim_q;
	logic              wr;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= WS_RESET;
			trim_q <= TRIM_RESET;
		end else if (wr) begin
			case (idx)
				REG_WINDOW_SIZE: ws_q <= pwdata[WS_W-1:0];
				REG_TRIM_COUNT:  trim_q <= pwdata[TRIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WINDOW_SIZE: prdata = PDATA_W'(ws_q);
			REG_TRIM_COUNT:  prdata = PDATA_W'(trim_q);
			default:         prdata = '0;
		endcase
	end

	// any write restarts the window
	assign cfg = '{window_size: ws_q, trim_count: trim_q, restart: wr};

endmodule

// File: hw/rtl/swtm_checker.sv
// port-level checker for the trimmed mean block, with its bind
`include "assert_macros.svh"

module swtm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           smp_valid,
	input logic                           smp_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [swtm_pkg::AVERAGE_W-1:0] res_average,
	input logic                           res_valid_res
);
	import swtm_pkg::*;

	`SWTM_ASSERT_STAYS(a_res_valid_holds, clk, arst_n, res_valid && !res_ready, res_valid, "result valid dropped while stalled")
	`SWTM_ASSERT_PROP(a_res_payload_holds, clk, arst_n, res_valid && !res_ready |=> $stable(res_average) && $stable(res_valid_res), "result payload changed while stalled")
	`SWTM_ASSERT_PROP(a_busy_after_sample, clk, arst_n, smp_valid && smp_ready |=> !smp_ready, "sample taken while previous one still in work")
	`SWTM_ASSERT_PROP(a_no_instant_result, clk, arst_n, smp_valid && smp_ready |=> !$rose(res_valid), "result appeared one cycle after sample transfer")
	`SWTM_ASSERT_PROP(a_invalid_is_zero, clk, arst_n, res_valid && !res_valid_res |-> res_average == '0, "invalid result carries a nonzero average")

endmodule

bind sliding_window_trimmed_mean swtm_checker u_swtm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.smp_valid     (smp.valid),
	.smp_ready     (smp.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_average   (res.average),
	.res_valid_res (res.valid_res)
);
